// ----- rtl/nafs_pkg.sv -----
package nafs_pkg;

  // Fixed nesting and quote bytes.
  localparam logic [7:0] BRACE_OPEN_CHAR   = 8'd123;
  localparam logic [7:0] BRACE_CLOSE_CHAR  = 8'd125;
  localparam logic [7:0] SINGLE_QUOTE_CHAR = 8'd39;
  localparam logic [7:0] DOUBLE_QUOTE_CHAR = 8'd34;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_DELIMITER  = 2'd0,
    CFG_LIST_OPEN  = 2'd1,
    CFG_LIST_CLOSE = 2'd2
  } cfg_index_t;

  localparam logic [7:0] DELIMITER_RESET  = 8'd44;
  localparam logic [7:0] LIST_OPEN_RESET  = 8'd91;
  localparam logic [7:0] LIST_CLOSE_RESET = 8'd93;

  // One result as it is held in the output queue.
  typedef struct packed {
    logic [31:0] field_offset;
    logic [31:0] field_length;
    logic        final_field;
  } field_result_t;

endpackage

// ----- rtl/nafs_in_if.sv -----
interface nafs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       first_of_span;
  logic       last_of_span;

  modport source (output valid, output byte_value, output first_of_span,
                  output last_of_span, input ready);
  modport sink (input valid, input byte_value, input first_of_span,
                input last_of_span, output ready);
endinterface

// ----- rtl/nafs_out_if.sv -----
interface nafs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] field_offset;
  logic [31:0] field_length;
  logic        final_field;

  modport source (output valid, output field_offset, output field_length,
                  output final_field, input ready);
  modport sink (input valid, input field_offset, input field_length,
                input final_field, output ready);
endinterface

// ----- rtl/nesting_aware_field_splitter.sv -----
// A result enters the registered queue when its byte is transferred and leaves it in order.
// One byte per cycle while the queue has room; a byte that yields two fields pushes two entries.
// The four-entry result queue sets the rate: a byte is taken while two entries are free.
// Reset (rst, synchronous, active high) zeroes position, field start, depths, quote
// toggles and the queue pointers and count, and loads the delimiter and list bracket
// registers with their default bytes (comma, open and close square bracket).
module nesting_aware_field_splitter #(
  parameter int DEPTH_BITS    = 8,
  parameter int POSITION_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [nafs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  nafs_in_if.sink                        in_item,
  nafs_out_if.source                     out_item
);
  import nafs_pkg::*;

  // Wide enough to hold a position and to cut it to the 32-bit result fields.
  localparam int EXT_BITS   = (POSITION_BITS > 32) ? POSITION_BITS : 32;
  localparam int QUEUE_SIZE = 4;
  localparam int PTR_BITS   = 2;

  // Configuration registers.
  logic [7:0] delimiter_char;
  logic [7:0] list_open_char;
  logic [7:0] list_close_char;

  // Scanner state.
  logic [POSITION_BITS-1:0] stream_position;
  logic [POSITION_BITS-1:0] field_start;
  logic [DEPTH_BITS-1:0]    bracket_depth;
  logic [DEPTH_BITS-1:0]    brace_depth;
  logic                     in_double_quote;
  logic                     in_single_quote;

  // Result queue.
  field_result_t       queue [QUEUE_SIZE];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;

  logic accept;
  logic pop;

  // Per-byte update signals.
  logic [POSITION_BITS-1:0] start_base;
  logic [POSITION_BITS-1:0] start_after;
  logic [POSITION_BITS-1:0] pos_plus_one;
  logic [DEPTH_BITS-1:0]    bracket_base;
  logic [DEPTH_BITS-1:0]    brace_base;
  logic                     dquote_base;
  logic                     squote_base;
  logic [DEPTH_BITS-1:0]    bracket_depth_next;
  logic [DEPTH_BITS-1:0]    brace_depth_next;
  logic                     in_double_quote_next;
  logic                     in_single_quote_next;
  logic                     delim_hit;
  logic [EXT_BITS-1:0]      delim_offset_ext;
  logic [EXT_BITS-1:0]      delim_length_ext;
  logic [EXT_BITS-1:0]      last_offset_ext;
  logic [EXT_BITS-1:0]      last_length_ext;
  field_result_t            delim_result;
  field_result_t            last_result;
  field_result_t            first_push;
  logic [1:0]               push_count;

  // A byte is taken only when the queue can absorb both results it may cause.
  // The count is a registered value, so ready does not depend on out_item.ready.
  assign in_item.ready = (count <= (PTR_BITS+1)'(QUEUE_SIZE - 2));
  assign accept        = in_item.valid && in_item.ready;
  assign pop           = out_item.valid && out_item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_char  <= DELIMITER_RESET;
      list_open_char  <= LIST_OPEN_RESET;
      list_close_char <= LIST_CLOSE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DELIMITER:  delimiter_char  <= cfg_data;
        CFG_LIST_OPEN:  list_open_char  <= cfg_data;
        CFG_LIST_CLOSE: list_close_char <= cfg_data;
        default: ;
      endcase
    end
  end

  // The first byte of a span clears nesting and quotes and opens a field at its position.
  always_comb begin
    start_base   = in_item.first_of_span ? stream_position : field_start;
    bracket_base = in_item.first_of_span ? '0 : bracket_depth;
    brace_base   = in_item.first_of_span ? '0 : brace_depth;
    dquote_base  = in_item.first_of_span ? 1'b0 : in_double_quote;
    squote_base  = in_item.first_of_span ? 1'b0 : in_single_quote;
    pos_plus_one = stream_position + POSITION_BITS'(1);

    bracket_depth_next   = bracket_base;
    brace_depth_next     = brace_base;
    in_double_quote_next = dquote_base;
    in_single_quote_next = squote_base;
    delim_hit            = 1'b0;

    // Nesting and quote bytes win over the delimiter, in this fixed order.
    if (in_item.byte_value == list_open_char) begin
      bracket_depth_next = bracket_base + DEPTH_BITS'(1);
    end else if (in_item.byte_value == list_close_char) begin
      bracket_depth_next = bracket_base - DEPTH_BITS'(1);
    end else if (in_item.byte_value == BRACE_OPEN_CHAR) begin
      brace_depth_next = brace_base + DEPTH_BITS'(1);
    end else if (in_item.byte_value == BRACE_CLOSE_CHAR) begin
      brace_depth_next = brace_base - DEPTH_BITS'(1);
    end else if (in_item.byte_value == SINGLE_QUOTE_CHAR) begin
      in_single_quote_next = ~squote_base;
    end else if (in_item.byte_value == DOUBLE_QUOTE_CHAR) begin
      in_double_quote_next = ~dquote_base;
    end else begin
      delim_hit = (bracket_base == '0) && (brace_base == '0) && !dquote_base &&
                  !squote_base && (in_item.byte_value == delimiter_char);
    end

    start_after = delim_hit ? pos_plus_one : start_base;

    // Lengths wrap at the position width, then everything is cut to 32 bits.
    delim_offset_ext = EXT_BITS'(start_base);
    delim_length_ext = EXT_BITS'(POSITION_BITS'(stream_position - start_base));
    last_offset_ext  = EXT_BITS'(start_after);
    last_length_ext  = EXT_BITS'(POSITION_BITS'(pos_plus_one - start_after));

    delim_result.field_offset = delim_offset_ext[31:0];
    delim_result.field_length = delim_length_ext[31:0];
    delim_result.final_field  = 1'b0;
    last_result.field_offset  = last_offset_ext[31:0];
    last_result.field_length  = last_length_ext[31:0];
    last_result.final_field   = 1'b1;

    // The delimiter field, when there is one, goes ahead of the closing field.
    first_push = delim_hit ? delim_result : last_result;
    push_count = accept ? (2'(delim_hit) + 2'(in_item.last_of_span)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_position <= '0;
      field_start     <= '0;
      bracket_depth   <= '0;
      brace_depth     <= '0;
      in_double_quote <= 1'b0;
      in_single_quote <= 1'b0;
    end else if (accept) begin
      stream_position <= pos_plus_one;
      field_start     <= start_after;
      bracket_depth   <= bracket_depth_next;
      brace_depth     <= brace_depth_next;
      in_double_quote <= in_double_quote_next;
      in_single_quote <= in_single_quote_next;
    end
  end

  // Queue entries carry no reset; the count says which are live.
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      queue[wr_ptr] <= first_push;
    end
    if (push_count == 2'd2) begin
      queue[wr_ptr + PTR_BITS'(1)] <= last_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count + (PTR_BITS+1)'(push_count) - (PTR_BITS+1)'(pop);
    end
  end

  assign out_item.valid        = (count != '0);
  assign out_item.field_offset = queue[rd_ptr].field_offset;
  assign out_item.field_length = queue[rd_ptr].field_length;
  assign out_item.final_field  = queue[rd_ptr].final_field;

endmodule
